FILE: hw/rtl/assert_macros.svh
// Shared assertion shorthands for the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/isfp_pkg.sv
package isfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Bytes held before the checksum byte arrives.
  localparam int SUM_LEN     = 10;
  localparam int FILL_W      = 4;
  localparam int AXIS_W      = 28;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_GYRO  = 2'd2,
    KIND_ANGLE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } frame_rec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  function automatic kind_t kind_of(logic [7:0] frame_type);
    kind_t k;
    case (frame_type)
      TYPE_ACCEL: k = KIND_ACCEL;
      TYPE_GYRO:  k = KIND_GYRO;
      TYPE_ANGLE: k = KIND_ANGLE;
      default:    k = KIND_OTHER;
    endcase
    return k;
  endfunction

  // Exact Q16 scaling as shift-and-add: x32, x4000 = 4096-64-32, x360 = 256+64+32+8.
  function automatic logic signed [AXIS_W-1:0] scale_axis(kind_t k, logic signed [15:0] raw);
    logic signed [AXIS_W-1:0] r;
    logic signed [AXIS_W-1:0] s;
    r = {{(AXIS_W-16){raw[15]}}, raw};
    case (k)
      KIND_ACCEL: s = r <<< 5;
      KIND_GYRO:  s = (r <<< 12) - (r <<< 6) - (r <<< 5);
      KIND_ANGLE: s = (r <<< 8) + (r <<< 6) + (r <<< 5) + (r <<< 3);
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/isfp_front.sv
`include "assert_macros.svh"

module isfp_front import isfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_stall,
  input  logic [7:0]    rx_byte,
  input  queue_status_t qstat,
  output logic          push,
  output frame_rec_t    push_rec
);

  logic [7:0]        window [SUM_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        sum;
  logic [7:0]        sum_next;
  logic              accept;
  logic              store_en;
  logic              slide_en;

  assign rx_stall = qstat.full;
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    fill_next = fill;
    sum_next  = sum;
    store_en  = 1'b0;
    slide_en  = 1'b0;
    push      = 1'b0;
    if (accept) begin
      if (fill == '0) begin
        // drop anything that is not a header while empty
        if (rx_byte == HEADER_BYTE) begin
          store_en  = 1'b1;
          fill_next = FILL_W'(1);
          sum_next  = rx_byte;
        end
      end else if (window[0] != HEADER_BYTE) begin
        fill_next = '0;
      end else if (fill < FILL_W'(SUM_LEN)) begin
        store_en  = 1'b1;
        fill_next = fill + FILL_W'(1);
        sum_next  = sum + rx_byte;
      end else if (sum == rx_byte) begin
        push      = 1'b1;
        fill_next = '0;
      end else begin
        // bad checksum: slide by one and keep ten bytes
        slide_en = 1'b1;
        sum_next = sum - window[0] + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else begin
      fill <= fill_next;
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (slide_en) begin
      for (int i = 0; i < SUM_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[SUM_LEN-1] <= rx_byte;
    end else if (store_en) begin
      for (int i = 0; i < SUM_LEN; i++) begin
        if (fill == FILL_W'(i)) begin
          window[i] <= rx_byte;
        end
      end
    end
  end

  assign push_rec.frame_type = window[1];
  assign push_rec.raw_x      = {window[3], window[2]};
  assign push_rec.raw_y      = {window[5], window[4]};
  assign push_rec.raw_z      = {window[7], window[6]};

  `ASSERT_ALWAYS(a_fill_range, clk, rst, fill <= FILL_W'(SUM_LEN), "fill count out of range")
  `ASSERT_NEXT(a_push_clears, clk, rst, push, fill == '0, "window not cleared after frame")

endmodule

FILE: hw/rtl/isfp_queue.sv
`include "assert_macros.svh"

module isfp_queue import isfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_rec_t    wr_rec,
  input  logic          pop,
  output frame_rec_t    rd_rec,
  output queue_status_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !qstat.full;
  assign do_pop  = pop && qstat.not_empty;

  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == CNT_W'(DEPTH));
  assign rd_rec          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst, push, !qstat.full, "push into full queue")
  `ASSERT_IMPL(a_no_underflow, clk, rst, pop, qstat.not_empty, "pop from empty queue")

endmodule

FILE: hw/rtl/isfp_back.sv
`include "assert_macros.svh"

module isfp_back import isfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  queue_status_t            qstat,
  input  frame_rec_t               rd_rec,
  output logic                     pop,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               frame_type,
  output logic [1:0]               kind,
  output logic signed [AXIS_W-1:0] axis_x,
  output logic signed [AXIS_W-1:0] axis_y,
  output logic signed [AXIS_W-1:0] axis_z
);

  kind_t head_kind;

  assign head_kind = kind_of(rd_rec.frame_type);
  assign pop       = qstat.not_empty && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_type <= rd_rec.frame_type;
      kind       <= head_kind;
      axis_x     <= scale_axis(head_kind, rd_rec.raw_x);
      axis_y     <= scale_axis(head_kind, rd_rec.raw_y);
      axis_z     <= scale_axis(head_kind, rd_rec.raw_z);
    end
  end

  `ASSERT_IMPL(a_other_zero, clk, rst, res_valid && (kind == KIND_OTHER), (axis_x == '0) && (axis_y == '0) && (axis_z == '0), "nonzero axis on unknown type")

endmodule

FILE: hw/rtl/imu_serial_frame_parser.sv
// IMU serial frame parser.
// Input channel (rx_valid / rx_stall / rx_byte): one received serial byte per
// item. Bytes gather into 11-byte frames: 0x55 header, type, eight data bytes,
// checksum equal to the 8-bit sum of the first ten bytes.
// Result channel (res_valid / res_stall): one item per good frame with the
// type byte, a kind code and three axes scaled to Q16 (accel x32, gyro x4000,
// angle x360); unknown types give kind 0 and zero axes.
// Throughput: one byte per cycle while rx_stall is low; the collector updates
// a running sum, so the checksum check costs nothing extra when the last
// byte lands. The queue takes a good frame on the edge that accepts its
// checksum byte; the scaling stage loads it into the output register once
// it is at the queue head and the output register is empty or being taken.
// A two-entry queue parts the collector from the output stage; rx_stall rises
// only when that queue is full, i.e. a stalled result sits in the output
// register with two more waiting behind it.
// While res_stall is high the result holds; bytes flow until the queue fills.
// Reset clears the fill count, the queue and res_valid; the window is
// refilled from the next header byte.
module imu_serial_frame_parser import isfp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rx_valid,
  output logic                     rx_stall,
  input  logic [7:0]               rx_byte,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               frame_type,
  output logic [1:0]               kind,
  output logic signed [AXIS_W-1:0] axis_x,
  output logic signed [AXIS_W-1:0] axis_y,
  output logic signed [AXIS_W-1:0] axis_z
);

  queue_status_t qstat;
  frame_rec_t    push_rec;
  frame_rec_t    rd_rec;
  logic          push;
  logic          pop;

  // Front: collect bytes, track the running checksum, push good frames.
  isfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .qstat    (qstat),
    .push     (push),
    .push_rec (push_rec)
  );

  // Hold finished frames so byte intake stalls only once the queue is full.
  isfp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .qstat  (qstat)
  );

  // Back: classify the type, scale the axes, drive the result register.
  isfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .rd_rec     (rd_rec),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .frame_type (frame_type),
    .kind       (kind),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z)
  );

endmodule

FILE: sim/imu_serial_frame_parser_test.sv
module imu_serial_frame_parser_test;
  import isfp_pkg::*;

  localparam int FRAME_LEN    = SUM_LEN + 1;
  // Rough count of bytes to send, ignored noise bytes not included.
  localparam int BYTE_TARGET  = 1810;
  // Results pass through the queue and output register; leave slack for both.
  localparam int DRAIN_CYCLES = 30;
  localparam int ACCEL_SCALE  = 32;
  localparam int GYRO_SCALE   = 4000;
  localparam int ANGLE_SCALE  = 360;
  localparam logic [7:0] TYPE_TIME = 8'h50;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_RUNS
  } stall_mode_t;

  // One decoded IMU reading as the result channel should carry it.
  typedef struct {
    logic [7:0]               ftype;
    kind_t                    kind_code;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
  } imu_reading_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     rx_valid = 1'b0;
  logic                     rx_stall;
  logic [7:0]               rx_byte = 8'h00;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic [7:0]               frame_type;
  logic [1:0]               kind;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;

  imu_serial_frame_parser dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .frame_type (frame_type),
    .kind       (kind),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z)
  );

  // Serial bytes waiting to go out, and readings the parser still owes us.
  logic [7:0]   tx_bytes[$];
  imu_reading_t pending_readings[$];

  // Our own copy of the frame collector.
  logic [7:0]   window_bytes[FRAME_LEN];
  int           window_fill = 0;

  int           error_count = 0;
  int           bytes_taken = 0;
  int           readings_checked = 0;
  int           kinds_seen[4] = '{0, 0, 0, 0};
  int           noise_bytes = 0;
  imu_reading_t oldest_reading;
  logic         rx_fire = 1'b0;

  // Sender burst/gap state and receiver stall state.
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_tick = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int           run_left = 0;
  logic         run_level = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Sign-extend a little-endian 16-bit axis from the window and scale it to Q16.
  function automatic logic signed [AXIS_W-1:0] axis_q16(int lo, int mult);
    logic signed [31:0] prod;
    prod = $signed({window_bytes[lo + 1], window_bytes[lo]}) * mult;
    return prod[AXIS_W-1:0];
  endfunction

  // Feed one accepted byte into the collector model; queue a reading when a
  // frame with a good checksum completes.
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0]   sum;
    imu_reading_t r;
    int           mult;
    // Drop stray bytes while hunting for a header.
    if (window_fill == 0 && b != HEADER_BYTE) return;
    window_bytes[window_fill] = b;
    window_fill++;
    if (window_fill < 2) return;
    // Lost header: only reachable after a slide put a non-header byte first.
    if (window_bytes[0] != HEADER_BYTE) begin
      window_fill = 0;
      return;
    end
    if (window_fill < FRAME_LEN) return;
    sum = 8'h00;
    for (int i = 0; i < SUM_LEN; i++) sum += window_bytes[i];
    // Bad checksum: slide by one and wait for the next byte to close it again.
    if (sum != window_bytes[SUM_LEN]) begin
      for (int i = 0; i < SUM_LEN; i++) window_bytes[i] = window_bytes[i + 1];
      window_fill = SUM_LEN;
      return;
    end
    r.ftype = window_bytes[1];
    case (window_bytes[1])
      TYPE_ACCEL: begin
        r.kind_code = KIND_ACCEL;
        mult = ACCEL_SCALE;
      end
      TYPE_GYRO: begin
        r.kind_code = KIND_GYRO;
        mult = GYRO_SCALE;
      end
      TYPE_ANGLE: begin
        r.kind_code = KIND_ANGLE;
        mult = ANGLE_SCALE;
      end
      default: begin
        r.kind_code = KIND_OTHER;
        mult = 0;
      end
    endcase
    r.ax = axis_q16(2, mult);
    r.ay = axis_q16(4, mult);
    r.az = axis_q16(6, mult);
    pending_readings.push_back(r);
    window_fill = 0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Queue one frame. A nonzero skew spoils the checksum; realign appends the
  // byte that makes the slid window a good frame (a real frame only when the
  // type byte is itself a header, otherwise it trips the lost-header drop).
  task automatic queue_frame(input logic [7:0] ftype, input logic [15:0] x, y, z,
                             input logic [7:0] skew, input bit realign);
    logic [7:0] fb[FRAME_LEN];
    logic [7:0] sum;
    fb[0] = HEADER_BYTE;
    fb[1] = ftype;
    {fb[3], fb[2]} = x;
    {fb[5], fb[4]} = y;
    {fb[7], fb[6]} = z;
    fb[8] = 8'($urandom);
    fb[9] = 8'($urandom);
    sum = 8'h00;
    for (int i = 0; i < SUM_LEN; i++) sum += fb[i];
    fb[SUM_LEN] = sum + skew;
    foreach (fb[i]) tx_bytes.push_back(fb[i]);
    if (realign) begin
      sum = 8'h00;
      for (int i = 1; i < FRAME_LEN; i++) sum += fb[i];
      tx_bytes.push_back(sum);
    end
  endtask

  // Mostly random axis values, with the 16-bit extremes mixed in.
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2: return TYPE_ACCEL;
      3, 4:    return TYPE_GYRO;
      5, 6:    return TYPE_ANGLE;
      7:       return TYPE_TIME;
      8:       return HEADER_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic plan_traffic();
    int roll;
    int n;
    // Directed: stray bytes while idle, then each frame kind, mostly at extremes.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    queue_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    queue_frame(TYPE_GYRO,  16'h7FFF, 16'h8000, 16'hFFFF, 8'h00, 1'b0);
    queue_frame(TYPE_ANGLE, 16'h8000, 16'h0001, 16'h7FFF, 8'h00, 1'b0);
    queue_frame(TYPE_TIME,  16'h1234, 16'hABCD, 16'h8000, 8'h00, 1'b0);
    // Bad checksum, then a header byte that the lost-header drop swallows.
    queue_frame(TYPE_ACCEL, 16'h0100, 16'h0200, 16'h0300, 8'h01, 1'b0);
    tx_bytes.push_back(HEADER_BYTE);
    queue_frame(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
    // Bad checksum on a frame whose type is a header: the slid window recovers.
    queue_frame(HEADER_BYTE, 16'h8051, 16'h7FFF, 16'h8000, 8'h80, 1'b1);

    // Random: mostly good frames, some broken, truncated or pure noise.
    while (tx_bytes.size() < noise_bytes + BYTE_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        queue_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(), 8'h00, 1'b0);
      end else if (roll < 86) begin
        queue_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(),
                    8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
      end else if (roll < 94) begin
        tx_bytes.push_back(HEADER_BYTE);
        n = $urandom_range(0, 9);
        repeat (n) tx_bytes.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) tx_bytes.push_back(8'($urandom));
        noise_bytes += n;
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps. Hold the byte
  // while the parser stalls it.
  always @(negedge clk) begin
    if (!rst) begin
      if (!(rx_valid && !rx_fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          rx_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            // A quarter of the bursts run straight on with no gap.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: move between randomly picked modes: no stall, coin flips, a
  // fixed duty pattern and random-length stall runs.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     res_stall <= 1'b0;
      STALL_COIN:     res_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: res_stall <= (stall_tick % 7) < 4;
      default: begin
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left = $urandom_range(1, 20);
        end else begin
          run_left--;
        end
        res_stall <= run_level;
      end
    endcase
  end

  // Monitor: check each delivered reading against the oldest owed one, then
  // advance the collector model with any byte taken on this edge.
  always @(posedge clk) begin
    if (rst) begin
      rx_fire <= 1'b0;
    end else begin
      rx_fire <= rx_valid && !rx_stall;
      if (res_valid && !res_stall) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual type %0h kind %0d",
                   $time, frame_type, kind);
          error_count++;
        end else begin
          oldest_reading = pending_readings.pop_front();
          check_field("frame_type", oldest_reading.ftype, frame_type);
          check_field("kind", oldest_reading.kind_code, kind);
          check_field("axis_x", oldest_reading.ax, axis_x);
          check_field("axis_y", oldest_reading.ay, axis_y);
          check_field("axis_z", oldest_reading.az, axis_z);
          kinds_seen[oldest_reading.kind_code]++;
          readings_checked++;
        end
      end
      if (rx_valid && !rx_stall) begin
        parse_byte(rx_byte);
        bytes_taken++;
      end
    end
  end

  initial begin
    plan_traffic();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Wait for the last byte to go in, then for every owed reading.
    @(posedge clk);
    while (tx_bytes.size() != 0 || rx_valid) @(posedge clk);
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes; checked %0d readings: accel %0d, gyro %0d, angle %0d, other %0d",
             bytes_taken, readings_checked, kinds_seen[KIND_ACCEL], kinds_seen[KIND_GYRO],
             kinds_seen[KIND_ANGLE], kinds_seen[KIND_OTHER]);
    if (error_count == 0) begin
      $display("imu_serial_frame_parser_test: clean");
    end else begin
      $display("imu_serial_frame_parser_test: errors");
    end
    $finish;
  end

  // Watchdog, set well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("timeout waiting for the parser");
    $display("imu_serial_frame_parser_test: errors");
    $finish;
  end

endmodule

FILE: imu_serial_frame_parser.f
+incdir+hw/rtl
hw/rtl/isfp_pkg.sv
hw/rtl/isfp_front.sv
hw/rtl/isfp_queue.sv
hw/rtl/isfp_back.sv
hw/rtl/imu_serial_frame_parser.sv
sim/imu_serial_frame_parser_test.sv
